[design/assert_macros.svh]
// Assertion macros shared by checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define AST_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define AST_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

[design/aes_pkg.sv]
// AES package: byte tables and GF(2^8) helpers
package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned KeyWords  = 2 * (NumRounds + 1);

    typedef logic [7:0]   byte_t;
    typedef logic [127:0] blk_t;

    // register indexes
    localparam logic [0:0] RegKeyHigh = 1'b0;
    localparam logic [0:0] RegKeyLow  = 1'b1;

    function automatic byte_t xt(input byte_t a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t gmul(input byte_t a, input byte_t b);
        byte_t r;
        byte_t p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r = r ^ p;
            p = xt(p);
        end
        gmul = r;
    endfunction

    function automatic byte_t sbox(input byte_t x);
        byte_t t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    function automatic byte_t inv_sbox(input byte_t s);
        byte_t t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sbox = t[s];
    endfunction

    // byte i of a block, byte 0 at the top
    function automatic byte_t bget(input blk_t b, input int i);
        bget = b[127-8*i -: 8];
    endfunction

    localparam logic [3:0] ShiftMap [16] =
        '{4'd0,4'd5,4'd10,4'd15,4'd4,4'd9,4'd14,4'd3,
          4'd8,4'd13,4'd2,4'd7,4'd12,4'd1,4'd6,4'd11};

endpackage

[design/aes_round.sv]
// Shared AES round unit: one forward or inverse round
module aes_round
(
    input  logic                dec,
    input  logic                last,
    input  aes_pkg::blk_t       state_in,
    input  aes_pkg::blk_t       rkey,
    output aes_pkg::blk_t       state_out
);

    aes_pkg::blk_t sb;
    aes_pkg::blk_t mc;

    always_comb
    begin
        sb = '0;
        mc = '0;
        for (int j = 0; j < 16; j++)
        begin
            if (!dec)
                sb[127-8*j -: 8] = aes_pkg::sbox(aes_pkg::bget(state_in, int'(aes_pkg::ShiftMap[j])));
            else
                sb[127-8*int'(aes_pkg::ShiftMap[j]) -: 8] =
                    aes_pkg::inv_sbox(aes_pkg::bget(state_in, j));
        end
        if (dec)
            sb = sb ^ rkey;
        for (int c = 0; c < 16; c += 4)
        begin
            aes_pkg::byte_t c0, c1, c2, c3;
            c0 = aes_pkg::bget(sb, c);
            c1 = aes_pkg::bget(sb, c+1);
            c2 = aes_pkg::bget(sb, c+2);
            c3 = aes_pkg::bget(sb, c+3);
            if (!dec)
            begin
                mc[127-8*c -: 8]     = aes_pkg::xt(c0)^aes_pkg::xt(c1)^c1^c2^c3;
                mc[127-8*(c+1) -: 8] = c0^aes_pkg::xt(c1)^aes_pkg::xt(c2)^c2^c3;
                mc[127-8*(c+2) -: 8] = c0^c1^aes_pkg::xt(c2)^aes_pkg::xt(c3)^c3;
                mc[127-8*(c+3) -: 8] = aes_pkg::xt(c0)^c0^c1^c2^aes_pkg::xt(c3);
            end
            else
            begin
                mc[127-8*c -: 8] = aes_pkg::gmul(c0,8'd14)^aes_pkg::gmul(c1,8'd11)
                    ^aes_pkg::gmul(c2,8'd13)^aes_pkg::gmul(c3,8'd9);
                mc[127-8*(c+1) -: 8] = aes_pkg::gmul(c0,8'd9)^aes_pkg::gmul(c1,8'd14)
                    ^aes_pkg::gmul(c2,8'd11)^aes_pkg::gmul(c3,8'd13);
                mc[127-8*(c+2) -: 8] = aes_pkg::gmul(c0,8'd13)^aes_pkg::gmul(c1,8'd9)
                    ^aes_pkg::gmul(c2,8'd14)^aes_pkg::gmul(c3,8'd11);
                mc[127-8*(c+3) -: 8] = aes_pkg::gmul(c0,8'd11)^aes_pkg::gmul(c1,8'd13)
                    ^aes_pkg::gmul(c2,8'd9)^aes_pkg::gmul(c3,8'd14);
            end
        end
        if (last)
            state_out = dec ? sb : (sb ^ rkey);
        else
            state_out = dec ? mc : (mc ^ rkey);
    end

endmodule

[design/aes_key_step.sv]
// One round of AES-128 key schedule
module aes_key_step
(
    input  aes_pkg::blk_t   prev,
    input  aes_pkg::byte_t  rc,
    output aes_pkg::blk_t   next
);

    always_comb
    begin
        next = '0;
        next[127:120] = aes_pkg::sbox(aes_pkg::bget(prev,13)) ^ aes_pkg::bget(prev,0) ^ rc;
        next[119:112] = aes_pkg::sbox(aes_pkg::bget(prev,14)) ^ aes_pkg::bget(prev,1);
        next[111:104] = aes_pkg::sbox(aes_pkg::bget(prev,15)) ^ aes_pkg::bget(prev,2);
        next[103:96]  = aes_pkg::sbox(aes_pkg::bget(prev,12)) ^ aes_pkg::bget(prev,3);
        for (int i = 4; i < 16; i++)
            next[127-8*i -: 8] = next[127-8*(i-4) -: 8] ^ aes_pkg::bget(prev, i);
    end

endmodule

[design/aes128_block_cipher.sv]
// AES-128 ECB block cipher top level with key store and round sequencer
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 writes
//    key_high, index 1 key_low; other indexes are ignored. cfg_ready is high
//    always. A key write marks the round keys stale.
//  - Input channel (in_valid/in_stall): req_type, block_high, block_low.
//    in_stall is high while an item is in progress or its result waits.
//  - Output channel (out_valid/out_stall): result_high, result_low.
// Sequence: with fresh keys an accepted item passes S_INIT (initial key add),
// then ten rounds in S_ROUND through the one shared round unit, then S_OUT
// raises out_valid. With stale keys, S_KEY key-schedule steps come first,
// writing the 11-entry key store.
// Items: one at a time; the next is taken only in S_IDLE after the result is
// handed off; the shared round unit is the limit.
// Reset: keys return to zero and are marked stale, the sequencer idles.
// Output stall: the result holds in the output register and no new item is
// taken until it is delivered.
module aes128_block_cipher
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         req_type,
    input  logic [63:0]  block_high,
    input  logic [63:0]  block_low,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [63:0]  result_high,
    output logic [63:0]  result_low
);

    typedef enum logic [2:0] {S_IDLE, S_KEY, S_INIT, S_ROUND, S_OUT} state_t;

    state_t              state_reg;
    logic [63:0]         key_high_reg;
    logic [63:0]         key_low_reg;
    logic                stale_reg;
    logic [3:0]          round_reg;
    logic                dec_reg;
    aes_pkg::blk_t       blk_reg;
    aes_pkg::blk_t       kprev_reg;
    aes_pkg::byte_t      rc_reg;
    aes_pkg::blk_t       kstore [aes_pkg::NumRounds+1];
    aes_pkg::blk_t       rkey;
    aes_pkg::blk_t       rnd_out;
    aes_pkg::blk_t       key_next;
    logic [3:0]          kidx;
    logic                last;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign result_high = blk_reg[127:64];
    assign result_low  = blk_reg[63:0];

    // encrypt walks key r = 1..10, decrypt 10-r = 9..0
    assign last = (round_reg == 4'(aes_pkg::NumRounds));
    assign kidx = (state_reg == S_INIT) ? (dec_reg ? 4'(aes_pkg::NumRounds) : 4'd0)
                : (dec_reg ? 4'(aes_pkg::NumRounds) - round_reg : round_reg);
    assign rkey = kstore[kidx];

    aes_round u_round
    (
        .dec       (dec_reg),
        .last      (last),
        .state_in  (blk_reg),
        .rkey      (rkey),
        .state_out (rnd_out)
    );

    aes_key_step u_kstep
    (
        .prev (kprev_reg),
        .rc   (rc_reg),
        .next (key_next)
    );

    // key store, written one round key per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && stale_reg)
            kstore[0] <= {key_high_reg, key_low_reg};
        else if (state_reg == S_KEY)
            kstore[round_reg] <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            stale_reg    <= 1'b1;
            round_reg    <= '0;
            dec_reg      <= 1'b0;
            rc_reg       <= 8'h01;
            blk_reg      <= '0;
            kprev_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    aes_pkg::RegKeyHigh: key_high_reg <= cfg_data;
                    aes_pkg::RegKeyLow:  key_low_reg  <= cfg_data;
                    default: ;
                endcase
            end
            // a key write always wins over the end of an expansion
            if (cfg_valid)
                stale_reg <= 1'b1;
            else if (state_reg == S_KEY && last)
                stale_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        dec_reg <= req_type;
                        blk_reg <= {block_high, block_low};
                        if (stale_reg)
                        begin
                            kprev_reg <= {key_high_reg, key_low_reg};
                            rc_reg    <= 8'h01;
                            round_reg <= 4'd1;
                            state_reg <= S_KEY;
                        end
                        else
                            state_reg <= S_INIT;
                    end
                end
                S_KEY:
                begin
                    kprev_reg <= key_next;
                    rc_reg    <= aes_pkg::xt(rc_reg);
                    if (last)
                        state_reg <= S_INIT;
                    else
                        round_reg <= round_reg + 4'd1;
                end
                S_INIT:
                begin
                    blk_reg   <= blk_reg ^ rkey;
                    round_reg <= 4'd1;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    blk_reg <= rnd_out;
                    if (last)
                    begin
                        round_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                        round_reg <= round_reg + 4'd1;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[design/aes_checker.sv]
// Port-level checker for the AES block, bound to the top level
`include "assert_macros.svh"
module aes_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] result_high
);
    `AST_IMPL(a_busy_out, clk, rst_n, out_valid, in_stall)
    `AST_NEXT(a_acc_busy, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)
    `AST_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(result_high))
endmodule

bind aes128_block_cipher aes_port_checker u_aes_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_high (result_high)
);

[tb/sv/aes_tb_pkg.sv]
// Shared testbench codes for the AES-128 cipher bench
package aes_tb_pkg;

    typedef enum logic {
        ReqEncrypt = 1'b0,
        ReqDecrypt = 1'b1
    } req_e;

endpackage

[tb/sv/aes_checker.sv]
// Checker for the AES-128 cipher: tracks the key, predicts each block and compares results
module aes_checker
    import aes_pkg::*;
    import aes_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] result_high,
    input  logic [63:0] result_low,
    output int          fail_count,
    output int          pending
);

    byte_t sub_tab [256];
    byte_t inv_tab [256];
    blk_t  round_key [NumRounds + 1];
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic  keys_stale;
    blk_t  expected_blocks [$];

    function automatic byte_t dbl(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r = r ^ a;
            a = dbl(a);
        end
        return r;
    endfunction

    // a^254, zero maps to zero
    function automatic byte_t gf_inv(input byte_t a);
        byte_t r;
        r = 8'h01;
        for (int i = 0; i < 254; i++)
            r = gf_mul(r, a);
        return r;
    endfunction

    function automatic byte_t rotl(input byte_t x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    initial
    begin
        byte_t y;
        byte_t s;
        for (int v = 0; v < 256; v++)
        begin
            y = gf_inv(byte_t'(v));
            s = y ^ rotl(y, 1) ^ rotl(y, 2) ^ rotl(y, 3) ^ rotl(y, 4) ^ 8'h63;
            sub_tab[v] = s;
            inv_tab[s] = byte_t'(v);
        end
    end

    function automatic void expand_round_keys();
        byte_t p [16];
        byte_t n [16];
        byte_t rc;
        rc = 8'h01;
        round_key[0] = {key_hi, key_lo};
        for (int j = 0; j < 16; j++)
            p[j] = round_key[0][127 - 8 * j -: 8];
        for (int r = 1; r <= NumRounds; r++)
        begin
            n[0] = sub_tab[p[13]] ^ p[0] ^ rc;
            n[1] = sub_tab[p[14]] ^ p[1];
            n[2] = sub_tab[p[15]] ^ p[2];
            n[3] = sub_tab[p[12]] ^ p[3];
            for (int j = 4; j < 16; j++)
                n[j] = n[j - 4] ^ p[j];
            for (int j = 0; j < 16; j++)
                round_key[r][127 - 8 * j -: 8] = n[j];
            p = n;
            rc = dbl(rc);
        end
    endfunction

    function automatic blk_t aes_transform(input blk_t blk, input req_e dir);
        byte_t a [16];
        byte_t b [16];
        byte_t c0, c1, c2, c3;
        blk_t  res;
        for (int j = 0; j < 16; j++)
            a[j] = blk[127 - 8 * j -: 8];
        if (dir == ReqEncrypt)
        begin
            for (int j = 0; j < 16; j++)
                a[j] ^= round_key[0][127 - 8 * j -: 8];
            for (int r = 1; r <= NumRounds; r++)
            begin
                for (int j = 0; j < 16; j++)
                    b[j] = sub_tab[a[ShiftMap[j]]];
                if (r < NumRounds)
                begin
                    for (int j = 0; j < 16; j += 4)
                    begin
                        c0 = b[j]; c1 = b[j + 1]; c2 = b[j + 2]; c3 = b[j + 3];
                        a[j]     = dbl(c0) ^ dbl(c1) ^ c1 ^ c2 ^ c3;
                        a[j + 1] = c0 ^ dbl(c1) ^ dbl(c2) ^ c2 ^ c3;
                        a[j + 2] = c0 ^ c1 ^ dbl(c2) ^ dbl(c3) ^ c3;
                        a[j + 3] = dbl(c0) ^ c0 ^ c1 ^ c2 ^ dbl(c3);
                    end
                end
                else
                    a = b;
                for (int j = 0; j < 16; j++)
                    a[j] ^= round_key[r][127 - 8 * j -: 8];
            end
        end
        else
        begin
            for (int j = 0; j < 16; j++)
                a[j] ^= round_key[NumRounds][127 - 8 * j -: 8];
            for (int r = NumRounds; r >= 1; r--)
            begin
                for (int j = 0; j < 16; j++)
                    b[ShiftMap[j]] = inv_tab[a[j]];
                for (int j = 0; j < 16; j++)
                    b[j] ^= round_key[r - 1][127 - 8 * j -: 8];
                if (r > 1)
                begin
                    for (int j = 0; j < 16; j += 4)
                    begin
                        c0 = b[j]; c1 = b[j + 1]; c2 = b[j + 2]; c3 = b[j + 3];
                        a[j]     = gf_mul(c0, 14) ^ gf_mul(c1, 11) ^ gf_mul(c2, 13)
                                 ^ gf_mul(c3, 9);
                        a[j + 1] = gf_mul(c0, 9) ^ gf_mul(c1, 14) ^ gf_mul(c2, 11)
                                 ^ gf_mul(c3, 13);
                        a[j + 2] = gf_mul(c0, 13) ^ gf_mul(c1, 9) ^ gf_mul(c2, 14)
                                 ^ gf_mul(c3, 11);
                        a[j + 3] = gf_mul(c0, 11) ^ gf_mul(c1, 13) ^ gf_mul(c2, 9)
                                 ^ gf_mul(c3, 14);
                    end
                end
                else
                    a = b;
            end
        end
        for (int j = 0; j < 16; j++)
            res[127 - 8 * j -: 8] = a[j];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        blk_t want;
        if (!rst_n)
        begin
            key_hi     = '0;
            key_lo     = '0;
            keys_stale = 1'b1;
            expected_blocks.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // key writes are to land only while idle, so no item races them; the checker does not enforce it
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == RegKeyHigh)
                    key_hi = cfg_data;
                else
                    key_lo = cfg_data;
                keys_stale = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                if (keys_stale)
                begin
                    expand_round_keys();
                    keys_stale = 1'b0;
                end
                expected_blocks.push_back(aes_transform({block_high, block_low},
                                                        req_e'(req_type)));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected result %h %h", result_high, result_low);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (want[127:64] !== result_high || want[63:0] !== result_low)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h %h, got %h %h",
                                     want[127:64], want[63:0], result_high, result_low);
                    end
                end
            end
            pending = expected_blocks.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// Top of the AES-128 cipher bench: clock, reset, stimulus, stalls and verdict
module tb;
    import aes_pkg::*;
    import aes_tb_pkg::*;

    localparam int CycleLimit = 300000;
    localparam int PhaseItems = 125;
    localparam int NumPhases  = 6;
    // covers key schedule plus a full block with margin
    localparam int SettleCycles = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = RegKeyHigh;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = ReqEncrypt;
    logic [63:0] block_high = '0;
    logic [63:0] block_low = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] result_high;
    logic [63:0] result_low;

    int fail_count;
    int pending;
    int cycles = 0;

    // no_idle: both sides run back to back; hold_req: one long output hold-off
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    always #2 clk = ~clk;

    aes128_block_cipher dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .block_high  (block_high),
        .block_low   (block_low),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_high (result_high),
        .result_low  (result_low)
    );

    aes_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .block_high  (block_high),
        .block_low   (block_low),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_high (result_high),
        .result_low  (result_low),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stall before each item, one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 9);
            if (hold_req && !hold_done)
            begin
                n = 400;
                hold_done = 1'b1;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // offer one item; valid stays high into the next item when no gap is drawn
    task automatic offer(input req_e dir, input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= dir;
        block_high <= hi;
        block_low  <= lo;
        do @(posedge clk); while (in_stall);
    endtask

    // wait until every expected result is back and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // key update; only called once drained
    task automatic load_key(input bit wr_hi, input logic [63:0] hi,
                            input bit wr_lo, input logic [63:0] lo);
        if (wr_hi)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= RegKeyHigh;
            cfg_data  <= hi;
            do @(posedge clk); while (!cfg_ready);
        end
        if (wr_lo)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= RegKeyLow;
            cfg_data  <= lo;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        logic [63:0] ones;
        ones = '1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no key ever written: the all-zero reset key is expanded
        offer(ReqEncrypt, '0, '0);
        offer(ReqEncrypt, ones, ones);
        offer(ReqDecrypt, '0, '0);
        offer(ReqDecrypt, ones, ones);
        offer(ReqEncrypt, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a);
        offer(ReqDecrypt, 64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5);
        drain();

        // standard test vector key, both directions
        load_key(1'b1, 64'h0001020304050607, 1'b1, 64'h08090a0b0c0d0e0f);
        offer(ReqEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
        offer(ReqDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        offer(ReqEncrypt, '0, '0);
        offer(ReqDecrypt, ones, '0);
        drain();

        // all-ones key
        load_key(1'b1, ones, 1'b1, ones);
        offer(ReqEncrypt, ones, ones);
        offer(ReqDecrypt, ones, ones);
        offer(ReqEncrypt, '0, '0);
        offer(ReqDecrypt, '0, '0);
        offer(ReqEncrypt, 64'h8000000000000000, 64'h0000000000000001);
        drain();

        // random phases, a new key each; phase 2 changes only the low half
        for (int p = 0; p < NumPhases; p++)
        begin
            if (p == 0)
                load_key(1'b1, '0, 1'b1, '0);
            else if (p == NumPhases - 1)
                load_key(1'b1, ones, 1'b1, ones);
            else if (p == 2)
                load_key(1'b0, '0, 1'b1, {$urandom, $urandom});
            else
                load_key(1'b1, {$urandom, $urandom}, 1'b1, {$urandom, $urandom});
            no_idle = (p == 1);
            if (p == 3)
                hold_req = 1'b1;
            for (int i = 0; i < PhaseItems; i++)
                offer(req_e'($urandom_range(0, 1)), rand_word(), rand_word());
            drain();
            no_idle = 1'b0;
        end

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
